// ===== rtl/rspf_pkg.sv =====
`timescale 1ns / 1ps

package rspf_pkg;

  localparam int WordW  = 16;
  localparam int LinesW = 12;
  localparam int ModeW  = 1;

  // Stream decode phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_COUNT  = 2'd2;
  localparam logic [1:0] PH_PIXEL  = 2'd3;

  // Configuration register indexes
  localparam logic [0:0] CFG_LINE_COUNT   = 1'b0;
  localparam logic [0:0] CFG_CONVERT_MODE = 1'b1;

  // Conversion modes
  localparam logic [ModeW-1:0] MODE_565_TO_555 = 1'b0;
  localparam logic [ModeW-1:0] MODE_555_TO_565 = 1'b1;

  localparam logic [WordW-1:0] MASK_565_RG = 16'hffc0;
  localparam logic [WordW-1:0] MASK_BLUE   = 16'h001f;
  localparam logic [WordW-1:0] MASK_555_RG = 16'h7fe0;

  localparam logic [LinesW-1:0] LINE_COUNT_RST = 12'd1;

  typedef struct packed {
    logic is_pixel;
    logic sprite_done;
  } word_status_t;

endpackage

// ===== rtl/rle_sprite_pixel_format_converter_top.sv =====
`timescale 1ns / 1ps

// Run-length sprite pixel format converter.
// Input stream: one 16-bit sprite stream word per transfer on in_tdata.
// Each line opens with a run count; each run is a skip word, a pixel count
// and that many pixels. Control words pass through; pixels are converted
// 565 -> 555 or 555 -> 565 depending on the convert_mode register.
// Output stream: one transfer per input transfer. out_tdata carries the word,
// out_tuser flags a converted pixel, out_tlast marks the word that completes
// the final line of the sprite, after which decoding starts a new sprite.
// Configuration: cfg_index 0 writes line_count (also reloads the lines still
// to go), cfg_index 1 writes convert_mode (bit 0). Always ready; write only
// while the stream is idle.
// Path: an accepted word is held in the input register, then in the result
// register, from which it is presented. Throughput is one word per cycle while
// the receiver does not stall; the decode counters are updated in the same cycle
// that moves a word from the input register to the result register.
// Reset (synchronous, rst_n low) empties both registers and returns the
// decoder to the start of a sprite with line_count 1 and 565 -> 555 mode.
// When the receiver stalls, the result register holds its word and one more
// word is taken into the input register; in_tready then drops.
module rle_sprite_pixel_format_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] stream_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] out_word
  output logic        out_tuser,  // [0] is_pixel
  output logic        out_tlast,  // sprite_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic                        in_valid_r;
  logic [rspf_pkg::WordW-1:0]  in_word_r;
  logic                        out_valid_r;
  logic [rspf_pkg::WordW-1:0]  out_word_r, out_word_nxt;
  logic                        out_pixel_r;
  logic                        out_done_r;
  logic [rspf_pkg::ModeW-1:0]  mode_r;

  logic                        advance;
  logic                        step;
  logic                        cfg_fire;
  logic                        line_we;
  rspf_pkg::word_status_t      status;

  // The result register can take a word when empty or draining this cycle
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign line_we   = cfg_fire && (cfg_index == rspf_pkg::CFG_LINE_COUNT);

  // Input register: hold the word until it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_word_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rspf_pkg::MODE_565_TO_555;
    end else if (cfg_fire && (cfg_index == rspf_pkg::CFG_CONVERT_MODE)) begin
      mode_r <= cfg_data[rspf_pkg::ModeW-1:0];
    end
  end

  rspf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .word       (in_word_r),
    .line_we    (line_we),
    .line_value (cfg_data),
    .status     (status)
  );

  rspf_conv u_conv (
    .word_in  (in_word_r),
    .mode     (mode_r),
    .is_pixel (status.is_pixel),
    .word_out (out_word_nxt)
  );

  // Result register: advance on a free slot, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r  <= out_word_nxt;
      out_pixel_r <= status.is_pixel;
      out_done_r  <= status.sprite_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_pixel_r;
  assign out_tlast  = out_done_r;

endmodule

// ===== rtl/rspf_conv.sv =====
`timescale 1ns / 1ps

module rspf_conv (
  input  logic [rspf_pkg::WordW-1:0] word_in,
  input  logic [rspf_pkg::ModeW-1:0] mode,
  input  logic                       is_pixel,
  output logic [rspf_pkg::WordW-1:0] word_out
);

  logic [rspf_pkg::WordW-1:0] to_555;
  logic [rspf_pkg::WordW-1:0] to_565;

  // 565 -> 555: drop low green bit; 555 -> 565: shift red/green up, bit 15 drops out
  assign to_555 = ((word_in & rspf_pkg::MASK_565_RG) >> 1) | (word_in & rspf_pkg::MASK_BLUE);
  assign to_565 = ((word_in & rspf_pkg::MASK_555_RG) << 1) | (word_in & rspf_pkg::MASK_BLUE);

  always_comb begin
    if (!is_pixel) begin
      word_out = word_in;
    end else if (mode == rspf_pkg::MODE_555_TO_565) begin
      word_out = to_565;
    end else begin
      word_out = to_555;
    end
  end

endmodule

// ===== rtl/rspf_ctrl.sv =====
`timescale 1ns / 1ps

module rspf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [rspf_pkg::WordW-1:0]  word,
  input  logic                        line_we,
  input  logic [rspf_pkg::LinesW-1:0] line_value,
  output rspf_pkg::word_status_t      status
);

  logic [1:0]                  phase_r, phase_nxt;
  logic [rspf_pkg::LinesW-1:0] line_count_r;
  logic [rspf_pkg::LinesW-1:0] lines_left_r, lines_left_nxt;
  logic [rspf_pkg::WordW-1:0]  runs_left_r, runs_left_nxt;
  logic [rspf_pkg::WordW-1:0]  pixels_left_r, pixels_left_nxt;

  logic [rspf_pkg::WordW-1:0]  runs_dec;
  logic [rspf_pkg::WordW-1:0]  pixels_dec;
  logic                        word_zero;
  logic                        last_line;
  logic                        line_end;
  logic                        run_end;

  assign runs_dec   = runs_left_r - rspf_pkg::WordW'(1);
  assign pixels_dec = pixels_left_r - rspf_pkg::WordW'(1);
  assign word_zero  = (word == '0);
  assign last_line  = (lines_left_r <= rspf_pkg::LinesW'(1));

  always_comb begin
    phase_nxt       = phase_r;
    runs_left_nxt   = runs_left_r;
    pixels_left_nxt = pixels_left_r;
    run_end         = 1'b0;
    line_end        = 1'b0;
    status          = '0;
    case (phase_r)
      rspf_pkg::PH_HEADER: begin
        if (word_zero) begin
          line_end = 1'b1;
        end else begin
          runs_left_nxt = word;
          phase_nxt     = rspf_pkg::PH_SKIP;
        end
      end
      rspf_pkg::PH_SKIP: begin
        phase_nxt = rspf_pkg::PH_COUNT;
      end
      rspf_pkg::PH_COUNT: begin
        if (word_zero) begin
          run_end = 1'b1;
        end else begin
          pixels_left_nxt = word;
          phase_nxt       = rspf_pkg::PH_PIXEL;
        end
      end
      default: begin
        status.is_pixel = 1'b1;
        pixels_left_nxt = pixels_dec;
        run_end         = (pixels_dec == '0);
      end
    endcase
    if (run_end) begin
      runs_left_nxt = runs_dec;
      if (runs_dec == '0) begin
        line_end = 1'b1;
      end else begin
        phase_nxt = rspf_pkg::PH_SKIP;
      end
    end
    if (line_end) begin
      phase_nxt          = rspf_pkg::PH_HEADER;
      status.sprite_done = last_line;
    end
  end

  always_comb begin
    if (line_end && last_line) begin
      lines_left_nxt = line_count_r;
    end else if (line_end) begin
      lines_left_nxt = lines_left_r - rspf_pkg::LinesW'(1);
    end else begin
      lines_left_nxt = lines_left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rspf_pkg::PH_HEADER;
      line_count_r  <= rspf_pkg::LINE_COUNT_RST;
      lines_left_r  <= rspf_pkg::LINE_COUNT_RST;
      runs_left_r   <= '0;
      pixels_left_r <= '0;
    end else if (line_we) begin
      line_count_r <= line_value;
      lines_left_r <= line_value;
    end else if (step) begin
      phase_r       <= phase_nxt;
      lines_left_r  <= lines_left_nxt;
      runs_left_r   <= runs_left_nxt;
      pixels_left_r <= pixels_left_nxt;
    end
  end

endmodule

// ===== rtl/rspf_checker.sv =====
`timescale 1ns / 1ps

module rspf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result holds its word and flags
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // Nothing is presented in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A draining output always leaves room for a new input word
  a_no_bubble: assert property (@(posedge clk)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // Either conversion leaves a known bit clear: bit 15 for 555, bit 5 for 565
  a_pixel_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[15] == 1'b0) || (out_tdata[5] == 1'b0))
    else $error("converted pixel has impossible bit pattern");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind rle_sprite_pixel_format_converter_top rspf_checker u_rspf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// ===== test/tb_rle_sprite_pixel_format_converter_top.sv =====
`timescale 1ns / 1ps

// One expected word on the output stream
typedef struct packed {
  logic [15:0] word;
  logic        is_pixel;
  logic        done;
} sprite_word_t;

// Tracks the sprite decoder state, predicts each output word and checks the
// words that leave the block against that prediction.
class sprite_word_checker;
  logic [11:0]  line_count;
  logic         convert_mode;
  logic [1:0]   phase;
  logic [11:0]  lines_left;
  logic [15:0]  runs_left;
  logic [15:0]  pixels_left;
  sprite_word_t expected_words[$];
  int           mismatches;

  function new();
    line_count   = rspf_pkg::LINE_COUNT_RST;
    convert_mode = rspf_pkg::MODE_565_TO_555;
    phase        = rspf_pkg::PH_HEADER;
    lines_left   = rspf_pkg::LINE_COUNT_RST;
    runs_left    = '0;
    pixels_left  = '0;
    mismatches   = 0;
  endfunction

  function void write_reg(logic [0:0] idx, logic [11:0] data);
    if (idx == rspf_pkg::CFG_LINE_COUNT) begin
      line_count = data;
      lines_left = data;
    end else begin
      convert_mode = data[0];
    end
  endfunction

  function logic [15:0] convert(logic [15:0] w);
    logic [15:0] px;
    if (convert_mode == rspf_pkg::MODE_555_TO_565)
      px = ((w & rspf_pkg::MASK_555_RG) << 1) | (w & rspf_pkg::MASK_BLUE);
    else px = ((w & rspf_pkg::MASK_565_RG) >> 1) | (w & rspf_pkg::MASK_BLUE);
    return px;
  endfunction

  // A line count of zero behaves as one: every line then ends the sprite
  function logic finish_line();
    phase = rspf_pkg::PH_HEADER;
    if (lines_left <= 12'd1) begin
      lines_left = line_count;
      return 1'b1;
    end
    lines_left = lines_left - 12'd1;
    return 1'b0;
  endfunction

  function logic finish_run();
    runs_left = runs_left - 16'd1;
    if (runs_left == 16'd0) return finish_line();
    phase = rspf_pkg::PH_SKIP;
    return 1'b0;
  endfunction

  function void note_word(logic [15:0] w);
    sprite_word_t r;
    r.word     = w;
    r.is_pixel = 1'b0;
    r.done     = 1'b0;
    case (phase)
      rspf_pkg::PH_HEADER: begin
        if (w == 16'd0) r.done = finish_line();
        else begin
          runs_left = w;
          phase     = rspf_pkg::PH_SKIP;
        end
      end
      rspf_pkg::PH_SKIP: phase = rspf_pkg::PH_COUNT;
      rspf_pkg::PH_COUNT: begin
        if (w == 16'd0) r.done = finish_run();
        else begin
          pixels_left = w;
          phase       = rspf_pkg::PH_PIXEL;
        end
      end
      default: begin
        r.word      = convert(w);
        r.is_pixel  = 1'b1;
        pixels_left = pixels_left - 16'd1;
        if (pixels_left == 16'd0) r.done = finish_run();
      end
    endcase
    expected_words.push_back(r);
  endfunction

  function void check_word(logic [15:0] word, logic is_pixel, logic done);
    sprite_word_t e;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected output word %h pix %b done %b", word, is_pixel, done);
      return;
    end
    e = expected_words.pop_front();
    if (e.word !== word || e.is_pixel !== is_pixel || e.done !== done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected word %h pix %b done %b, got word %h pix %b done %b",
                 e.word, e.is_pixel, e.done, word, is_pixel, done);
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module tb_rle_sprite_pixel_format_converter_top;

  localparam int unsigned CycleLimit = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [15:0] stream_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [15:0] out_word
  logic        out_tuser;        // [0] is_pixel
  logic        out_tlast;        // sprite_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = rspf_pkg::CFG_LINE_COUNT;
  logic [11:0] cfg_data = '0;

  // Random idling on both sides; cleared for one long stretch
  bit          idle_on = 1'b1;
  int unsigned cycle_count = 0;

  sprite_word_checker sb = new();

  rle_sprite_pixel_format_converter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: end the run as failed when cycle_count reaches CycleLimit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_rle_sprite_pixel_format_converter_top NOT OK");
      $finish;
    end
  end

  // Receiver side: stall at random, about 23 percent of the time, while idling is on
  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 23);
  end

  // Check every output transfer against the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
  end

  // Present one stream word after any random idle cycles and hold it until
  // the transfer; the prediction is made at the edge that accepts it. Valid
  // stays high afterwards until an idle cycle or a drain lowers it.
  task automatic send_word(input logic [15:0] w);
    while (idle_on && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(w);
  endtask

  // Drop valid and wait until every expected word has left the block
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One register write; only the last of a group lowers valid again
  task automatic write_reg(input logic [0:0] idx, input logic [11:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Write both registers in random order; random upper bits on the mode word
  task automatic set_config(input logic [11:0] lines, input logic mode);
    logic [11:0] mode_word;
    mode_word = {11'($urandom), mode};
    drain();
    if ($urandom_range(1) == 1) begin
      write_reg(rspf_pkg::CFG_LINE_COUNT, lines, 1'b0);
      write_reg(rspf_pkg::CFG_CONVERT_MODE, mode_word, 1'b1);
    end else begin
      write_reg(rspf_pkg::CFG_CONVERT_MODE, mode_word, 1'b0);
      write_reg(rspf_pkg::CFG_LINE_COUNT, lines, 1'b1);
    end
  endtask

  // Mostly well-formed sprites: short run and pixel counts with random skip
  // and pixel words, some zero counts, and a little noise with longer counts.
  function automatic logic [15:0] next_stream_word();
    int unsigned roll;
    logic [15:0] w;
    roll = $urandom_range(99);
    w    = 16'($urandom);
    if (roll < 6) begin
      if (sb.phase == rspf_pkg::PH_HEADER || sb.phase == rspf_pkg::PH_COUNT)
        w = w & 16'h003f;
    end else begin
      case (sb.phase)
        rspf_pkg::PH_HEADER: begin
          if (roll < 20) w = 16'd0;
          else if (roll < 88) w = 16'($urandom_range(1, 3));
          else w = 16'($urandom_range(4, 10));
        end
        rspf_pkg::PH_COUNT: begin
          if (roll < 18) w = 16'd0;
          else if (roll < 85) w = 16'($urandom_range(1, 5));
          else if (roll < 96) w = 16'($urandom_range(6, 20));
          else w = 16'($urandom_range(21, 60));
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  initial begin
    logic [11:0] lines;
    logic        mode;
    int          n_words;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: one line, 565 to 555
    send_word(16'h0000);  // zero run count ends the line and the sprite
    send_word(16'h0001);
    send_word(16'hffff);  // skip word, all ones
    send_word(16'h0000);  // zero pixel count ends the last run
    send_word(16'h0002);
    send_word(16'h0000);
    send_word(16'h0002);
    send_word(16'hffff);
    send_word(16'h0000);
    send_word(16'haaaa);
    send_word(16'h0001);
    send_word(16'h5555);

    // 555 to 565 with a line count of zero, which acts as one
    drain();
    write_reg(rspf_pkg::CFG_CONVERT_MODE, 12'hfff, 1'b0);
    write_reg(rspf_pkg::CFG_LINE_COUNT, 12'h000, 1'b1);
    send_word(16'h0001);
    send_word(16'h1234);
    send_word(16'h0003);
    send_word(16'hffff);
    send_word(16'h8000);  // top bit of the pixel is dropped
    send_word(16'h7fff);
    send_word(16'h0000);

    // Largest line count, left mid-sprite for the next reload
    drain();
    write_reg(rspf_pkg::CFG_LINE_COUNT, 12'hfff, 1'b0);
    write_reg(rspf_pkg::CFG_CONVERT_MODE, 12'hffe, 1'b1);
    send_word(16'h0001);
    send_word(16'h0000);
    send_word(16'h0001);
    send_word(16'hffff);

    // Random part: several settings, the extremes among them
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lines = 12'd3;    mode = rspf_pkg::MODE_555_TO_565; end
        1: begin lines = 12'd2;    mode = rspf_pkg::MODE_565_TO_555; end
        2: begin lines = 12'd1;    mode = rspf_pkg::MODE_555_TO_565; end
        3: begin lines = 12'd0;    mode = rspf_pkg::MODE_565_TO_555; end
        4: begin lines = 12'hfff;  mode = rspf_pkg::MODE_555_TO_565; end
        default: begin
          lines = 12'($urandom_range(1, 8));
          mode  = 1'($urandom_range(1));
        end
      endcase
      set_config(lines, mode);
      // Pass 2 is a long stretch with no idling on either side
      idle_on = (p != 2);
      n_words = (p == 2) ? 120 : 70;
      for (int i = 0; i < n_words; i++) send_word(next_stream_word());
    end
    idle_on = 1'b1;

    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_rle_sprite_pixel_format_converter_top OK");
    end else begin
      $display("tb_rle_sprite_pixel_format_converter_top NOT OK");
    end
    $finish;
  end

endmodule
